/* design/shrp_pkg.sv */
// Shared types and constants for the search-hit record parser.
// Holds the transaction payload structs, byte class codes and tag codes.
// No dependencies.
package shrp_pkg;

   // Text class codes carried in byte_class.
   localparam logic [3:0] CLASS_NONE     = 4'd0;
   localparam logic [3:0] CLASS_USER     = 4'd1;
   localparam logic [3:0] CLASS_EXT      = 4'd2;
   localparam logic [3:0] CLASS_HASH     = 4'd3;
   localparam logic [3:0] CLASS_TITLE    = 4'd4;
   localparam logic [3:0] CLASS_ARTIST   = 4'd5;
   localparam logic [3:0] CLASS_ALBUM    = 4'd6;
   localparam logic [3:0] CLASS_GENRE    = 4'd7;
   localparam logic [3:0] CLASS_COMMENTS = 4'd8;
   localparam logic [3:0] CLASS_YEAR     = 4'd9;
   localparam logic [3:0] CLASS_FILENAME = 4'd10;

   // Tag codes found in the tag loop.
   localparam logic [7:0] TAG_TITLE    = 8'h01;
   localparam logic [7:0] TAG_ARTIST   = 8'h02;
   localparam logic [7:0] TAG_ALBUM    = 8'h03;
   localparam logic [7:0] TAG_RATE     = 8'h04;
   localparam logic [7:0] TAG_YEAR     = 8'h06;
   localparam logic [7:0] TAG_FILENAME = 8'h10;

   // Field lengths in bytes.
   localparam logic [5:0] WORD_LEN   = 6'd4;
   localparam logic [5:0] PORT_LEN   = 6'd3;
   localparam logic [5:0] SKIP_LEN   = 6'd5;
   localparam logic [5:0] HASH_LEN   = 6'd20;
   localparam logic [5:0] RATE_LEN   = 6'd6;
   localparam logic [7:0] VIDEO_RESET = 8'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  byte_class;
      logic [7:0]  char_out;
      logic        packet_done;
      logic [31:0] query_key;
      logic [31:0] sender_ip;
      logic [7:0]  media_kind;
      logic [31:0] file_size;
      logic [15:0] bit_rate;
      logic [31:0] play_length;
      logic        truncated;
   } rsp_payload_type;

endpackage

/* design/search_hit_record_parser.sv */
// Search-hit record parser: one datagram byte in, one classified result out.
// Depends on shrp_pkg for payload structs, class codes and tag codes.
//
// The result of an accepted byte is in the output register in the next cycle.
// Throughput is one byte per cycle; the only stall comes from a held result.
// Synchronous active-high reset clears the parse state, the output valid and
// sets the video media code to 5.
module search_hit_record_parser
   import shrp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data
);

   typedef enum logic [3:0] {
      PH_HDR, PH_QID, PH_IP, PH_SKIP3, PH_USER, PH_SKIP6, PH_MEDIA,
      PH_SKIPB, PH_SIZE, PH_HASH, PH_EXT, PH_TAG, PH_STR, PH_RATE
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [4:0]      count_ff, count_in;
   logic [5:0]      count_plus;
   logic [3:0]      target_ff, target_in;
   logic            title_ff, title_in;
   logic            artist_ff, artist_in;
   logic            album_ff, album_in;
   logic            genre_ff, genre_in;
   logic [31:0]     query_ff, query_in;
   logic [31:0]     ip_ff, ip_in;
   logic [7:0]      media_ff, media_in;
   logic [31:0]     size_ff, size_in;
   logic [15:0]     rate_ff, rate_in;
   logic [31:0]     length_ff, length_in;
   logic [7:0]      video_code_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic            video;
   logic [7:0]      data;
   logic [3:0]      cls;
   logic [4:0]      lane_shift;
   logic [1:0]      rate_lane;
   logic [31:0]     length_lane;

   // Input is held off only while a finished result waits downstream.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign data       = req_payload.data_byte;
   assign video      = (media_ff == video_code_ff);
   assign count_plus = {1'b0, count_ff} + 6'd1;
   assign lane_shift = {count_ff[1:0], 3'b000};
   assign rate_lane  = 2'(count_ff - 5'd2);

   // Next parse state and result for the byte at the input.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      target_in   = target_ff;
      title_in    = title_ff;
      artist_in   = artist_ff;
      album_in    = album_ff;
      genre_in    = genre_ff;
      query_in    = query_ff;
      ip_in       = ip_ff;
      media_in    = media_ff;
      size_in     = size_ff;
      rate_in     = rate_ff;
      length_in   = length_ff;
      cls         = CLASS_NONE;
      length_lane = length_ff;

      case (phase_ff)
         PH_HDR: begin
            if (count_plus >= WORD_LEN) begin
               count_in = '0;
               phase_in = PH_QID;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_QID: begin
            query_in = query_ff | ({24'd0, data} << lane_shift);
            if (count_plus >= WORD_LEN) begin
               count_in = '0;
               phase_in = PH_IP;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_IP: begin
            ip_in = {ip_ff[23:0], data};
            if (count_plus >= WORD_LEN) begin
               count_in = '0;
               phase_in = PH_SKIP3;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_SKIP3: begin
            if (count_plus >= PORT_LEN) begin
               count_in = '0;
               phase_in = PH_USER;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_USER: begin
            if (data == 8'd0) begin
               phase_in = PH_SKIP6;
               count_in = '0;
            end else begin
               cls = CLASS_USER;
            end
         end
         PH_SKIP6: begin
            if (count_plus >= SKIP_LEN) begin
               count_in = '0;
               phase_in = PH_MEDIA;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_MEDIA: begin
            media_in = data;
            phase_in = PH_SKIPB;
         end
         PH_SKIPB: begin
            phase_in = PH_SIZE;
            count_in = '0;
         end
         PH_SIZE: begin
            size_in = size_ff | ({24'd0, data} << lane_shift);
            if (count_plus >= WORD_LEN) begin
               count_in = '0;
               phase_in = PH_HASH;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_HASH: begin
            cls = CLASS_HASH;
            if (count_plus >= HASH_LEN) begin
               count_in = '0;
               phase_in = PH_EXT;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         PH_EXT: begin
            if (data == 8'd0) begin
               phase_in = PH_TAG;
            end else begin
               cls = CLASS_EXT;
            end
         end
         PH_TAG: begin
            // The tag code picks the class of the text that follows.
            count_in  = '0;
            phase_in  = PH_STR;
            target_in = CLASS_NONE;
            case (data)
               TAG_TITLE: begin
                  target_in = title_ff ? CLASS_GENRE : CLASS_TITLE;
               end
               TAG_ARTIST: begin
                  target_in = artist_ff ? CLASS_NONE : CLASS_ARTIST;
               end
               TAG_ALBUM: begin
                  if (video) begin
                     target_in = genre_ff ? CLASS_COMMENTS : CLASS_GENRE;
                  end else begin
                     target_in = album_ff ? CLASS_COMMENTS : CLASS_ALBUM;
                  end
               end
               TAG_RATE: begin
                  if (rate_ff == 16'd0) begin
                     phase_in = PH_RATE;
                  end
               end
               TAG_YEAR: begin
                  target_in = CLASS_YEAR;
               end
               TAG_FILENAME: begin
                  target_in = CLASS_FILENAME;
               end
               default: begin
                  target_in = CLASS_NONE;
               end
            endcase
         end
         PH_STR: begin
            if (data == 8'd0) begin
               phase_in = PH_TAG;
            end else begin
               cls = target_ff;
               if (target_ff == CLASS_TITLE)  title_in  = 1'b1;
               if (target_ff == CLASS_ARTIST) artist_in = 1'b1;
               if (target_ff == CLASS_ALBUM)  album_in  = 1'b1;
               if (target_ff == CLASS_GENRE)  genre_in  = 1'b1;
            end
         end
         PH_RATE: begin
            // Bitrate in the first two bytes, then four bytes of media length.
            if (count_ff == 5'd0) begin
               rate_in = {8'd0, data};
            end else if (count_ff == 5'd1) begin
               rate_in = {data, rate_ff[7:0]};
            end else begin
               case (rate_lane)
                  2'd0:    length_lane = {length_ff[31:8], data};
                  2'd1:    length_lane = {length_ff[31:16], data, length_ff[7:0]};
                  2'd2:    length_lane = {length_ff[31:24], data, length_ff[15:0]};
                  default: length_lane = {data, length_ff[23:0]};
               endcase
            end
            length_in = length_lane;
            if (count_plus >= RATE_LEN) begin
               // Video keeps only the word at payload bytes three and four.
               if (video) begin
                  length_in = {16'd0, length_lane[23:8]};
               end
               phase_in = PH_TAG;
               count_in = '0;
            end else begin
               count_in = count_plus[4:0];
            end
         end
         default: begin
            phase_in = PH_HDR;
            count_in = '0;
         end
      endcase

      // Build the result; numeric fields show only on the last byte.
      rsp_payload_in             = '0;
      rsp_payload_in.byte_class  = cls;
      rsp_payload_in.char_out    = (cls != CLASS_NONE) ? data : 8'd0;
      rsp_payload_in.packet_done = req_payload.last_byte;
      if (req_payload.last_byte) begin
         rsp_payload_in.query_key    = query_in;
         rsp_payload_in.sender_ip    = ip_in;
         rsp_payload_in.media_kind   = media_in;
         rsp_payload_in.file_size    = size_in;
         rsp_payload_in.bit_rate     = rate_in;
         rsp_payload_in.play_length  = length_in;
         rsp_payload_in.truncated    = (phase_in < PH_TAG);

         // The packet is over: start the next one from a clean state.
         phase_in  = PH_HDR;
         count_in  = '0;
         target_in = CLASS_NONE;
         title_in  = 1'b0;
         artist_in = 1'b0;
         album_in  = 1'b0;
         genre_in  = 1'b0;
         query_in  = '0;
         ip_in     = '0;
         media_in  = '0;
         size_in   = '0;
         rate_in   = '0;
         length_in = '0;
      end
   end

   // Parse state, configuration and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR;
         count_ff      <= '0;
         target_ff     <= CLASS_NONE;
         title_ff      <= 1'b0;
         artist_ff     <= 1'b0;
         album_ff      <= 1'b0;
         genre_ff      <= 1'b0;
         query_ff      <= '0;
         ip_ff         <= '0;
         media_ff      <= '0;
         size_ff       <= '0;
         rate_ff       <= '0;
         length_ff     <= '0;
         video_code_ff <= VIDEO_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            video_code_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            count_ff       <= count_in;
            target_ff      <= target_in;
            title_ff       <= title_in;
            artist_ff      <= artist_in;
            album_ff       <= album_in;
            genre_ff       <= genre_in;
            query_ff       <= query_in;
            ip_ff          <= ip_in;
            media_ff       <= media_in;
            size_ff        <= size_in;
            rate_ff        <= rate_in;
            length_ff      <= length_in;
            rsp_payload_ff <= rsp_payload_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

endmodule
